/* sv/cmh_pkg.sv */
// ----------------------------------------------------------------------------
// cmh_pkg - shared types and constants for the conformal map hit block
// Field widths, register indexes and the record that travels down the
// divider pipeline.
// ----------------------------------------------------------------------------
package cmh_pkg;

   localparam int COORD_W   = 16;   // hit and reference coordinates
   localparam int SIG_W     = 12;   // spreads
   localparam int OUT_W     = 26;   // map_u, map_v
   localparam int VAR_W     = 48;   // var_v
   localparam int FRAC_BITS = 24;   // fixed-point scale of u, v and variance

   localparam int ABS_W   = COORD_W + 1;       // |dx|, |dy|
   localparam int SQ_W    = 2 * ABS_W - 1;     // dx^2, dy^2, dx*dy
   localparam int R2_W    = SQ_W + 1;          // r2
   localparam int D_W     = 2 * R2_W - 1;      // r2^2
   localparam int SIG2_W  = 2 * SIG_W;         // sigma^2
   localparam int N_W     = D_W + SIG2_W;      // variance numerator
   localparam int REM_W   = R2_W + 1;          // u/v remainder, below 2*r2
   localparam int Q_UV_W  = FRAC_BITS + 1;     // u/v quotient magnitude
   localparam int UV_STEPS  = Q_UV_W;
   localparam int DIV_STEPS = VAR_W + 1;       // two chained divisions, offset by one

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COORD_W;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_REF_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE = 2'd2;

   typedef struct packed {
      logic                 deg;
      logic                 neg_u;
      logic                 neg_v;
      logic [R2_W-1:0]      r2;
      logic [D_W-1:0]       d;
      logic [FRAC_BITS-1:0] n_lo;    // low numerator bits still to feed
      logic [D_W-1:0]       rem1;    // numerator / r2^2
      logic                 q1b;     // quotient bit handed to the second division
      logic [D_W-1:0]       rem2;    // quotient / r2^2
      logic [VAR_W-1:0]     var_q;
      logic [Q_UV_W-1:0]    feed;    // low dividend bits of u and v
      logic [REM_W-1:0]     rem_u;
      logic [REM_W-1:0]     rem_v;
      logic [Q_UV_W-1:0]    q_u;
      logic [Q_UV_W-1:0]    q_v;
      logic [OUT_W-1:0]     map_u;
      logic [OUT_W-1:0]     map_v;
   } div_type;

endpackage

/* sv/cmh_chan_if.sv */
// ----------------------------------------------------------------------------
// cmh channel interfaces - hit, result and register write channels
// Each carries valid, ready and its payload, with source and sink modports.
// ----------------------------------------------------------------------------
interface cmh_req_if;
   import cmh_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] hit_x;
   logic [COORD_W-1:0] hit_y;
   logic [SIG_W-1:0]   sigma_x;
   logic [SIG_W-1:0]   sigma_y;
   modport source (output valid, hit_x, hit_y, sigma_x, sigma_y, input ready);
   modport sink   (input valid, hit_x, hit_y, sigma_x, sigma_y, output ready);
endinterface

interface cmh_rsp_if;
   import cmh_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] map_u;
   logic [OUT_W-1:0] map_v;
   logic [VAR_W-1:0] var_v;
   logic             degenerate;
   modport source (output valid, map_u, map_v, var_v, degenerate, input ready);
   modport sink   (input valid, map_u, map_v, var_v, degenerate, output ready);
endinterface

interface cmh_csr_if;
   import cmh_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/conformal_map_hit.sv */
// ----------------------------------------------------------------------------
// conformal_map_hit - conformal mapping of detector hits
// Maps each hit relative to a reference point to u = dx/r2, v = dy/r2 and
// the variance of v, all scaled by 2^24.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  - one hit per beat: hit_x, hit_y, sigma_x, sigma_y.
//   rsp_chan  - one result per hit, in order: map_u, map_v, var_v, degenerate.
//   csr_chan  - register writes (ref_x, ref_y, rotate); always ready. Write
//               only while no hit is in flight.
// Throughput: one hit per clock while rsp_chan is not stalled. A hit passes
// seven stages of rotation, squaring and numerator products, then the 49
// restoring divider stages that produce the 48 variance bits (two chained
// divisions by r2^2, one bit per stage).
// A hit on the reference point yields zeros with degenerate set.
// Stall: the pipe advances as a whole; while a result waits on rsp_chan
// with ready low, every stage holds and req_chan.ready is low. Nothing is
// dropped or repeated.
// Reset (synchronous): clears all valid bits and ref_x, ref_y, rotate to zero.
// ----------------------------------------------------------------------------
module conformal_map_hit (
   input logic      clock,
   input logic      reset,
   cmh_req_if.sink  req_chan,
   cmh_rsp_if.source rsp_chan,
   cmh_csr_if.sink  csr_chan
);
   import cmh_pkg::*;

   typedef struct packed {
      logic [ABS_W-1:0] adx;
      logic [ABS_W-1:0] ady;
      logic             neg_x;
      logic             neg_y;
      logic [SIG_W-1:0] sx;
      logic [SIG_W-1:0] sy;
   } p0_type;

   typedef struct packed {
      logic [ABS_W-1:0]  adx;
      logic [ABS_W-1:0]  ady;
      logic              neg_x;
      logic              neg_y;
      logic [SQ_W-1:0]   ax2;
      logic [SQ_W-1:0]   ay2;
      logic [SQ_W-1:0]   axy;
      logic [SIG2_W-1:0] sx2;
      logic [SIG2_W-1:0] sy2;
   } p1_type;

   typedef struct packed {
      logic [ABS_W-1:0]  adx;
      logic [ABS_W-1:0]  ady;
      logic              neg_x;
      logic              neg_y;
      logic              deg;
      logic [R2_W-1:0]   r2;
      logic [SQ_W-1:0]   ua;
      logic [R2_W-1:0]   ub;
      logic [SIG2_W-1:0] sx2;
      logic [SIG2_W-1:0] sy2;
   } p2_type;

   typedef struct packed {
      logic [ABS_W-1:0]    adx;
      logic [ABS_W-1:0]    ady;
      logic                neg_x;
      logic                neg_y;
      logic                deg;
      logic [R2_W-1:0]     r2;
      logic [D_W-1:0]      d;
      logic [2*SQ_W-1:0]   ua2;
      logic [D_W-1:0]      ub2;
      logic [SIG2_W-1:0]   sx2;
      logic [SIG2_W-1:0]   sy2;
   } p3_type;

   typedef struct packed {
      logic [ABS_W-1:0]         adx;
      logic [ABS_W-1:0]         ady;
      logic                     neg_x;
      logic                     neg_y;
      logic                     deg;
      logic [R2_W-1:0]          r2;
      logic [D_W-1:0]           d;
      logic [SQ_W+SIG2_W-1:0]   na_lo;
      logic [SQ_W+SIG2_W-1:0]   na_hi;
      logic [R2_W+SIG2_W-1:0]   nb_lo;
      logic [SQ_W+SIG2_W-1:0]   nb_hi;
   } p4_type;

   typedef struct packed {
      logic [ABS_W-1:0] adx;
      logic [ABS_W-1:0] ady;
      logic             neg_x;
      logic             neg_y;
      logic             deg;
      logic [R2_W-1:0]  r2;
      logic [D_W-1:0]   d;
      logic [N_W-1:0]   na;
      logic [N_W-1:0]   nb;
   } p5_type;

   logic [COORD_W-1:0] ref_x_ff;
   logic [COORD_W-1:0] ref_y_ff;
   logic               rotate_ff;

   logic               adv;
   logic [5:0]         pv_ff;
   p0_type             p0_ff, p0_in;
   p1_type             p1_ff, p1_in;
   p2_type             p2_ff, p2_in;
   p3_type             p3_ff, p3_in;
   p4_type             p4_ff, p4_in;
   p5_type             p5_ff, p5_in;
   div_type            st0_in;
   div_type            st_ff [0:DIV_STEPS];
   logic               st_vld_ff [0:DIV_STEPS];

   logic [ABS_W-1:0]   hx;
   logic [ABS_W-1:0]   hy;
   logic [ABS_W-1:0]   rx;
   logic [ABS_W-1:0]   ry;
   logic [ABS_W-1:0]   xr;
   logic [ABS_W-1:0]   yr;
   logic [ABS_W-1:0]   x0r;
   logic [ABS_W-1:0]   y0r;
   logic [ABS_W:0]     dx;
   logic [ABS_W:0]     dy;
   logic [ABS_W:0]     ndx;
   logic [ABS_W:0]     ndy;
   logic [N_W-1:0]     num;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff  <= '0;
         ref_y_ff  <= '0;
         rotate_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_REF_X:  ref_x_ff  <= csr_chan.data;
            CSR_REF_Y:  ref_y_ff  <= csr_chan.data;
            CSR_ROTATE: rotate_ff <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

   // whole pipe moves unless the output beat is stalled
   assign adv            = !st_vld_ff[DIV_STEPS] || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 0: rotate, take differences and magnitudes
   always_comb begin
      hx  = {req_chan.hit_x[COORD_W-1], req_chan.hit_x};
      hy  = {req_chan.hit_y[COORD_W-1], req_chan.hit_y};
      rx  = {ref_x_ff[COORD_W-1], ref_x_ff};
      ry  = {ref_y_ff[COORD_W-1], ref_y_ff};
      xr  = rotate_ff ? hy : hx;
      yr  = rotate_ff ? ABS_W'(-hx) : hy;
      x0r = rotate_ff ? ry : rx;
      y0r = rotate_ff ? ABS_W'(-rx) : ry;
      dx  = {xr[ABS_W-1], xr} - {x0r[ABS_W-1], x0r};
      dy  = {yr[ABS_W-1], yr} - {y0r[ABS_W-1], y0r};
      ndx = -dx;
      ndy = -dy;
      p0_in.neg_x = dx[ABS_W];
      p0_in.neg_y = dy[ABS_W];
      p0_in.adx   = dx[ABS_W] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
      p0_in.ady   = dy[ABS_W] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];
      p0_in.sx    = req_chan.sigma_x;
      p0_in.sy    = req_chan.sigma_y;
   end

   // stage 1: squares
   always_comb begin
      p1_in.adx   = p0_ff.adx;
      p1_in.ady   = p0_ff.ady;
      p1_in.neg_x = p0_ff.neg_x;
      p1_in.neg_y = p0_ff.neg_y;
      p1_in.ax2   = SQ_W'(p0_ff.adx) * SQ_W'(p0_ff.adx);
      p1_in.ay2   = SQ_W'(p0_ff.ady) * SQ_W'(p0_ff.ady);
      p1_in.axy   = SQ_W'(p0_ff.adx) * SQ_W'(p0_ff.ady);
      p1_in.sx2   = SIG2_W'(p0_ff.sx) * SIG2_W'(p0_ff.sx);
      p1_in.sy2   = SIG2_W'(p0_ff.sy) * SIG2_W'(p0_ff.sy);
   end

   // stage 2: r2 and the two derivative terms
   always_comb begin
      p2_in.adx   = p1_ff.adx;
      p2_in.ady   = p1_ff.ady;
      p2_in.neg_x = p1_ff.neg_x;
      p2_in.neg_y = p1_ff.neg_y;
      p2_in.deg   = (p1_ff.adx == '0) && (p1_ff.ady == '0);
      p2_in.r2    = R2_W'(p1_ff.ax2) + R2_W'(p1_ff.ay2);
      p2_in.ua    = (p1_ff.ax2 >= p1_ff.ay2) ? SQ_W'(p1_ff.ax2 - p1_ff.ay2)
                                             : SQ_W'(p1_ff.ay2 - p1_ff.ax2);
      p2_in.ub    = {p1_ff.axy, 1'b0};
      p2_in.sx2   = p1_ff.sx2;
      p2_in.sy2   = p1_ff.sy2;
   end

   // stage 3: r2^2 and squared derivative terms
   always_comb begin
      p3_in.adx   = p2_ff.adx;
      p3_in.ady   = p2_ff.ady;
      p3_in.neg_x = p2_ff.neg_x;
      p3_in.neg_y = p2_ff.neg_y;
      p3_in.deg   = p2_ff.deg;
      p3_in.r2    = p2_ff.r2;
      p3_in.d     = D_W'(p2_ff.r2) * D_W'(p2_ff.r2);
      p3_in.ua2   = (2*SQ_W)'(p2_ff.ua) * (2*SQ_W)'(p2_ff.ua);
      p3_in.ub2   = D_W'(p2_ff.ub) * D_W'(p2_ff.ub);
      p3_in.sx2   = p2_ff.sx2;
      p3_in.sy2   = p2_ff.sy2;
   end

   // stage 4: weight by the spreads, split into partial products
   always_comb begin
      p4_in.adx   = p3_ff.adx;
      p4_in.ady   = p3_ff.ady;
      p4_in.neg_x = p3_ff.neg_x;
      p4_in.neg_y = p3_ff.neg_y;
      p4_in.deg   = p3_ff.deg;
      p4_in.r2    = p3_ff.r2;
      p4_in.d     = p3_ff.d;
      p4_in.na_lo = (SQ_W+SIG2_W)'(p3_ff.ua2[SQ_W-1:0]) * (SQ_W+SIG2_W)'(p3_ff.sy2);
      p4_in.na_hi = (SQ_W+SIG2_W)'(p3_ff.ua2[2*SQ_W-1:SQ_W]) * (SQ_W+SIG2_W)'(p3_ff.sy2);
      p4_in.nb_lo = (R2_W+SIG2_W)'(p3_ff.ub2[R2_W-1:0]) * (R2_W+SIG2_W)'(p3_ff.sx2);
      p4_in.nb_hi = (SQ_W+SIG2_W)'(p3_ff.ub2[D_W-1:R2_W]) * (SQ_W+SIG2_W)'(p3_ff.sx2);
   end

   // stage 5: recombine the partial products
   always_comb begin
      p5_in.adx   = p4_ff.adx;
      p5_in.ady   = p4_ff.ady;
      p5_in.neg_x = p4_ff.neg_x;
      p5_in.neg_y = p4_ff.neg_y;
      p5_in.deg   = p4_ff.deg;
      p5_in.r2    = p4_ff.r2;
      p5_in.d     = p4_ff.d;
      p5_in.na    = (N_W'(p4_ff.na_hi) << SQ_W) + N_W'(p4_ff.na_lo);
      p5_in.nb    = (N_W'(p4_ff.nb_hi) << R2_W) + N_W'(p4_ff.nb_lo);
   end

   // stage 6: numerator sum and divider set-up
   always_comb begin
      num          = p5_ff.na + p5_ff.nb;
      st0_in       = '0;
      st0_in.deg   = p5_ff.deg;
      st0_in.neg_u = p5_ff.neg_x;
      st0_in.neg_v = p5_ff.neg_y;
      st0_in.r2    = p5_ff.r2;
      st0_in.d     = p5_ff.d;
      st0_in.n_lo  = num[FRAC_BITS-1:0];
      st0_in.rem1  = num[N_W-1:FRAC_BITS];
      st0_in.feed  = p5_ff.r2[Q_UV_W-1:0];
      st0_in.rem_u = REM_W'(p5_ff.adx) + REM_W'(p5_ff.r2[R2_W-1:Q_UV_W]);
      st0_in.rem_v = REM_W'(p5_ff.ady) + REM_W'(p5_ff.r2[R2_W-1:Q_UV_W]);
   end

   // prologue valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= '0;
         st_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         pv_ff        <= {pv_ff[4:0], req_chan.valid};
         st_vld_ff[0] <= pv_ff[5];
      end
   end

   // prologue payload
   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         p4_ff    <= p4_in;
         p5_ff    <= p5_in;
         st_ff[0] <= st0_in;
      end
   end

   // divider pipeline
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      cmh_div_stage #(.STEP(k)) u_stage (
         .clock        (clock),
         .reset        (reset),
         .adv          (adv),
         .in_valid     (st_vld_ff[k]),
         .in_st        (st_ff[k]),
         .out_valid_ff (st_vld_ff[k+1]),
         .out_st_ff    (st_ff[k+1])
      );
   end

   // result beat
   assign rsp_chan.valid      = st_vld_ff[DIV_STEPS];
   assign rsp_chan.map_u      = st_ff[DIV_STEPS].map_u;
   assign rsp_chan.map_v      = st_ff[DIV_STEPS].map_v;
   assign rsp_chan.var_v      = st_ff[DIV_STEPS].var_q;
   assign rsp_chan.degenerate = st_ff[DIV_STEPS].deg;

`ifndef SYNTH
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.degenerate |->
         rsp_chan.map_u == '0 && rsp_chan.map_v == '0 && rsp_chan.var_v == '0)
      else $error("degenerate result with nonzero fields");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("hit taken while output beat is stalled");

   a_u_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         $signed(rsp_chan.map_u) <= $signed(27'sd16777216) &&
         $signed(rsp_chan.map_u) >= $signed(-27'sd16777216))
      else $error("map_u beyond unit magnitude");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid straight after reset");
`endif

endmodule

/* sv/cmh_div_stage.sv */
// ----------------------------------------------------------------------------
// cmh_div_stage - one registered step of the divider pipeline
// Runs one restoring step of numerator / r2^2, one step of that quotient
// / r2^2 (one stage behind), and while STEP < UV_STEPS one step each of the
// rounded u and v divisions by 2*r2.
// ----------------------------------------------------------------------------
module cmh_div_stage #(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  cmh_pkg::div_type in_st,
   output logic            out_valid_ff,
   output cmh_pkg::div_type out_st_ff
);
   import cmh_pkg::*;

   div_type            out_st_in;
   logic [D_W:0]       t1;
   logic [D_W:0]       t2;
   logic [D_W:0]       dd;
   logic [REM_W:0]     tu;
   logic [REM_W:0]     tv;
   logic [REM_W:0]     du;
   logic               g1;
   logic               g2;
   logic               gu;
   logic               gv;
   logic [Q_UV_W-1:0]  qu;
   logic [Q_UV_W-1:0]  qv;

   always_comb begin
      out_st_in = in_st;
      dd        = {1'b0, in_st.d};

      // first division: shift in the next numerator bit
      t1 = {in_st.rem1, in_st.n_lo[FRAC_BITS-1]};
      g1 = (t1 >= dd);
      out_st_in.n_lo = {in_st.n_lo[FRAC_BITS-2:0], 1'b0};
      out_st_in.rem1 = g1 ? D_W'(t1 - dd) : t1[D_W-1:0];
      out_st_in.q1b  = g1;

      // second division: consume the bit the previous stage produced
      t2 = {in_st.rem2, in_st.q1b};
      g2 = (t2 >= dd);
      out_st_in.rem2  = g2 ? D_W'(t2 - dd) : t2[D_W-1:0];
      out_st_in.var_q = {in_st.var_q[VAR_W-2:0], g2};

      // rounded u and v: (|dx| * 2^(F+1) + r2) / (2 * r2), likewise for |dy|
      du = {1'b0, in_st.r2, 1'b0};
      tu = {in_st.rem_u, in_st.feed[Q_UV_W-1]};
      tv = {in_st.rem_v, in_st.feed[Q_UV_W-1]};
      gu = (tu >= du);
      gv = (tv >= du);
      qu = {in_st.q_u[Q_UV_W-2:0], gu};
      qv = {in_st.q_v[Q_UV_W-2:0], gv};
      if (STEP < UV_STEPS) begin
         out_st_in.feed  = {in_st.feed[Q_UV_W-2:0], 1'b0};
         out_st_in.rem_u = gu ? REM_W'(tu - du) : tu[REM_W-1:0];
         out_st_in.rem_v = gv ? REM_W'(tv - du) : tv[REM_W-1:0];
         out_st_in.q_u   = qu;
         out_st_in.q_v   = qv;
      end

      // apply signs once the u and v quotients are complete
      if (STEP == UV_STEPS - 1) begin
         if (in_st.deg) begin
            out_st_in.map_u = '0;
            out_st_in.map_v = '0;
         end else begin
            out_st_in.map_u = in_st.neg_u ? OUT_W'(-{1'b0, qu}) : OUT_W'(qu);
            out_st_in.map_v = in_st.neg_v ? OUT_W'(-{1'b0, qv}) : OUT_W'(qv);
         end
      end

      // zero the variance of a hit on the reference point
      if (STEP == DIV_STEPS - 1 && in_st.deg) begin
         out_st_in.var_q = '0;
      end
   end

   // advance valid with the whole pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_st_ff <= out_st_in;
      end
   end

endmodule
